/* rtl/ldtw_pkg.sv */
// ldtw_pkg: shared types, command codes and byte selection for the two-wire led frame sender
// no dependencies; imported by every module of the block
`default_nettype none

package ldtw_pkg;

  localparam int DIGITS_DEFAULT = 4;
  localparam int SEG_FIELDS = 4;

  // action codes carried by an input item
  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_UPDATE = 2'd1;
  localparam logic [1:0] ACT_SINGLE = 2'd2;

  // configuration register indexes
  localparam logic REG_BRIGHTNESS    = 1'b0;
  localparam logic REG_START_ADDRESS = 1'b1;

  localparam logic [2:0] BRIGHTNESS_RESET    = 3'd7;
  localparam logic [7:0] START_ADDRESS_RESET = 8'hC0;

  // driver command bytes
  localparam logic [7:0] CMD_DATA_AUTO  = 8'h40;
  localparam logic [7:0] CMD_DATA_FIXED = 8'h44;
  localparam logic [7:0] CMD_ADDR_BASE  = 8'hC0;
  localparam logic [7:0] CMD_DISPLAY_ON = 8'h88;

  // frames of one sequence
  localparam logic [2:0] FRAME_CMD  = 3'd0;
  localparam logic [2:0] FRAME_DATA = 3'd1;
  localparam logic [2:0] FRAME_CTRL = 3'd2;
  localparam logic [2:0] FRAME_COUNT = 3'd3;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_START_A  = 4'd1,
    PH_START_B  = 4'd2,
    PH_BIT_LOW  = 4'd3,
    PH_BIT_HIGH = 4'd4,
    PH_ACK_LOW  = 4'd5,
    PH_ACK_HIGH = 4'd6,
    PH_STOP_A   = 4'd7,
    PH_STOP_B   = 4'd8,
    PH_STOP_C   = 4'd9
  } phase_t;

  typedef struct packed {
    logic [1:0] action;
    logic [1:0] position;
    logic [7:0] seg_a;
    logic [7:0] seg_b;
    logic [7:0] seg_c;
    logic [7:0] seg_d;
    logic       dio_in;
  } item_t;

  typedef struct packed {
    logic clk_line;
    logic dio_line;
    logic dio_drive;
    logic busy_res;
    logic refused;
    logic ack_missing;
    logic frame_done;
  } result_t;

  // byte to shift out next, chosen by frame and place in frame
  function automatic logic [7:0] load_value(
    input logic [2:0] frame_step,
    input logic       single_mode,
    input logic [2:0] byte_index,
    input logic [1:0] target_position,
    input logic [7:0] start_address,
    input logic [2:0] brightness,
    input logic [7:0] digit
  );
    logic [7:0] v;
    case (frame_step)
      FRAME_CMD: begin
        v = single_mode ? CMD_DATA_FIXED : CMD_DATA_AUTO;
      end
      FRAME_DATA: begin
        if (byte_index == 3'd0) begin
          v = single_mode ? (CMD_ADDR_BASE | {6'd0, target_position}) : start_address;
        end else begin
          v = digit;
        end
      end
      default: begin
        v = CMD_DISPLAY_ON + {5'd0, brightness};
      end
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* rtl/led_driver_two_wire_frame_sender.sv */
// Line sequencer for a two-wire seven-segment LED driver. Every transfer on the item channel is
// one half-bit tick and yields exactly one result transfer with the clock and data line levels for
// that tick; a request (four-digit update or single-digit write) accepted on an idle tick starts
// three frames (data command, address plus digits, display control) with start, LSB-first bytes,
// acknowledge slots and stop. One item is taken every cycle while the result queue has room; the
// sequencer state advances once per item. An item passes the item register, then the sequencer step
// into a two-entry result queue that keeps taking items while a result waits. Requests made while
// busy are refused; a high data line in an acknowledge slot sets a sticky flag that only reset
// clears. Configuration is to be written by the user only while no transfer is in progress.
// depends on ldtw_pkg, ldtw_seq and ldtw_res_queue
`default_nettype none

module led_driver_two_wire_frame_sender #(
  parameter int DIGITS = ldtw_pkg::DIGITS_DEFAULT
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // item channel
  input  wire logic         item_valid,
  output logic              item_stall,
  input  wire ldtw_pkg::item_t item,
  // result channel
  output logic              result_valid,
  input  wire logic         result_stall,
  output ldtw_pkg::result_t result,
  // configuration writes
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [7:0]   cfg_data
);
  import ldtw_pkg::*;

  // configuration registers
  logic [2:0] brightness;
  logic [7:0] start_address;

  // item register in front of the sequencer
  logic       stage_valid;
  item_t      stage_item;

  logic       queue_full;
  logic       go;
  result_t    step_result;

  // the staged item moves on whenever the result queue has room
  assign go         = stage_valid && !queue_full;
  assign item_stall = stage_valid && queue_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness    <= BRIGHTNESS_RESET;
      start_address <= START_ADDRESS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BRIGHTNESS:    brightness    <= cfg_data[2:0];
        REG_START_ADDRESS: start_address <= cfg_data;
        default:           brightness    <= brightness;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!item_stall) begin
      stage_valid <= item_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      stage_item <= item;
    end
  end

  ldtw_seq #(
    .DIGITS (DIGITS)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .go            (go),
    .item          (stage_item),
    .brightness    (brightness),
    .start_address (start_address),
    .result        (step_result)
  );

  ldtw_res_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .push         (go),
    .push_data    (step_result),
    .full         (queue_full),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // the last tick of a sequence always belongs to a transfer
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.frame_done) |-> result.busy_res)
    else $error("frame_done outside a transfer");

  // a refusal can only happen while a sequence runs
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.refused) |-> result.busy_res)
    else $error("request refused while idle");

  // released data line reads high and only happens inside a transfer
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.dio_drive) |-> (result.dio_line && result.busy_res))
    else $error("released data line not high or outside a transfer");

  // an item is never sequenced into a full queue
  assert property (@(posedge clk) disable iff (rst)
    (stage_valid && queue_full) |=> (stage_valid && $stable(stage_item)))
    else $error("staged item lost while result queue full");

endmodule

`default_nettype wire

/* rtl/ldtw_res_queue.sv */
// ldtw_res_queue: two-entry result queue that decouples the sequencer from the output stall
// depends on ldtw_pkg for the result struct
`default_nettype none

module ldtw_res_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire ldtw_pkg::result_t push_data,
  output logic                   full,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output ldtw_pkg::result_t      result
);
  import ldtw_pkg::*;

  result_t    entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop          = (count != 2'd0) && !result_stall;
  assign full         = (count == 2'd2);
  assign result_valid = (count != 2'd0);
  assign result       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/ldtw_seq.sv */
// ldtw_seq: half-bit tick sequencer, one step per registered item
// depends on ldtw_pkg for phase enum, item and result structs and command bytes
`default_nettype none

module ldtw_seq #(
  parameter int DIGITS = ldtw_pkg::DIGITS_DEFAULT
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         go,
  input  wire ldtw_pkg::item_t item,
  input  wire logic [2:0]   brightness,
  input  wire logic [7:0]   start_address,
  output ldtw_pkg::result_t result
);
  import ldtw_pkg::*;

  localparam int         IDX_W      = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam logic [3:0] NUM_DIGITS = 4'(DIGITS);
  localparam logic [2:0] AUTO_LEN   = 3'(DIGITS + 1);

  phase_t     phase, phase_next, eff_phase;
  logic [3:0] bit_count, bit_count_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [2:0] frame_step, frame_step_next;
  logic [2:0] byte_index, byte_index_next;
  logic       single_mode, single_mode_next;
  logic [1:0] target_position, target_position_next;
  logic       ack_flag, ack_flag_next;
  logic [7:0] digit_bytes [DIGITS];

  logic       request;
  logic       accept_req;
  logic [2:0] bi_inc;
  logic [2:0] fs_inc;
  logic [3:0] bc_inc;
  logic [2:0] frame_len;
  logic [2:0] digit_k;
  logic [7:0] digit_sel;
  logic [7:0] seg [SEG_FIELDS];

  assign seg[0] = item.seg_a;
  assign seg[1] = item.seg_b;
  assign seg[2] = item.seg_c;
  assign seg[3] = item.seg_d;

  assign request    = go && (item.action inside {ACT_UPDATE, ACT_SINGLE});
  assign accept_req = request && (phase == PH_IDLE);
  assign eff_phase  = accept_req ? PH_START_A : phase;
  assign bi_inc     = byte_index + 3'd1;
  assign fs_inc     = frame_step + 3'd1;
  assign bc_inc     = bit_count + 4'd1;
  assign frame_len  = (frame_step == FRAME_DATA) ? (single_mode ? 3'd2 : AUTO_LEN) : 3'd1;

  // digit loaded after byte_index advances: its place is the current byte_index
  assign digit_k   = single_mode ? 3'd0 : byte_index;
  assign digit_sel = ({1'b0, digit_k} < NUM_DIGITS) ? digit_bytes[digit_k[IDX_W-1:0]] : 8'd0;

  // digit store, written on an accepted request
  for (genvar g = 0; g < DIGITS; g++) begin : g_digit
    if (g < SEG_FIELDS) begin : g_seg
      always_ff @(posedge clk) begin
        if (accept_req) begin
          digit_bytes[g] <= seg[g];
        end
      end
    end else begin : g_blank
      always_ff @(posedge clk) begin
        if (accept_req) begin
          digit_bytes[g] <= 8'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      bit_count       <= 4'd0;
      shift_byte      <= 8'd0;
      frame_step      <= 3'd0;
      byte_index      <= 3'd0;
      single_mode     <= 1'b0;
      target_position <= 2'd0;
      ack_flag        <= 1'b0;
    end else begin
      phase           <= phase_next;
      bit_count       <= bit_count_next;
      shift_byte      <= shift_byte_next;
      frame_step      <= frame_step_next;
      byte_index      <= byte_index_next;
      single_mode     <= single_mode_next;
      target_position <= target_position_next;
      ack_flag        <= ack_flag_next;
    end
  end

  // next state
  always_comb begin
    phase_next           = phase;
    bit_count_next       = bit_count;
    shift_byte_next      = shift_byte;
    frame_step_next      = frame_step;
    byte_index_next      = byte_index;
    single_mode_next     = single_mode;
    target_position_next = target_position;
    ack_flag_next        = ack_flag;
    if (go) begin
      if (accept_req) begin
        single_mode_next     = (item.action == ACT_SINGLE);
        target_position_next = item.position;
        frame_step_next      = FRAME_CMD;
        byte_index_next      = 3'd0;
        shift_byte_next      = load_value(FRAME_CMD, single_mode_next, 3'd0, item.position,
                                          start_address, brightness, 8'd0);
        bit_count_next       = 4'd0;
      end
      case (eff_phase)
        PH_START_A:  phase_next = PH_START_B;
        PH_START_B:  phase_next = PH_BIT_LOW;
        PH_BIT_LOW:  phase_next = PH_BIT_HIGH;
        PH_BIT_HIGH: begin
          shift_byte_next = {1'b0, shift_byte[7:1]};
          bit_count_next  = bc_inc;
          phase_next      = (bc_inc >= 4'd8) ? PH_ACK_LOW : PH_BIT_LOW;
        end
        PH_ACK_LOW:  phase_next = PH_ACK_HIGH;
        PH_ACK_HIGH: begin
          ack_flag_next   = ack_flag | item.dio_in;
          byte_index_next = bi_inc;
          if (bi_inc < frame_len) begin
            shift_byte_next = load_value(frame_step, single_mode, bi_inc, target_position,
                                         start_address, brightness, digit_sel);
            bit_count_next  = 4'd0;
            phase_next      = PH_BIT_LOW;
          end else begin
            phase_next = PH_STOP_A;
          end
        end
        PH_STOP_A:   phase_next = PH_STOP_B;
        PH_STOP_B:   phase_next = PH_STOP_C;
        PH_STOP_C: begin
          byte_index_next = 3'd0;
          if (fs_inc < FRAME_COUNT) begin
            frame_step_next = fs_inc;
            shift_byte_next = load_value(fs_inc, single_mode, 3'd0, target_position,
                                         start_address, brightness, 8'd0);
            bit_count_next  = 4'd0;
            phase_next      = PH_START_A;
          end else begin
            frame_step_next = 3'd0;
            phase_next      = PH_IDLE;
          end
        end
        default:     phase_next = PH_IDLE;
      endcase
    end
  end

  // line levels and flags for this tick
  always_comb begin
    result.clk_line    = 1'b1;
    result.dio_line    = 1'b1;
    result.dio_drive   = 1'b1;
    result.busy_res    = 1'b1;
    result.refused     = request && (phase != PH_IDLE);
    result.ack_missing = ack_flag_next;
    result.frame_done  = 1'b0;
    case (eff_phase)
      PH_START_A:  result.dio_line = 1'b0;
      PH_START_B: begin
        result.clk_line = 1'b0;
        result.dio_line = 1'b0;
      end
      PH_BIT_LOW: begin
        result.clk_line = 1'b0;
        result.dio_line = shift_byte[0];
      end
      PH_BIT_HIGH: result.dio_line = shift_byte[0];
      PH_ACK_LOW: begin
        result.clk_line  = 1'b0;
        result.dio_drive = 1'b0;
      end
      PH_ACK_HIGH: result.dio_drive = 1'b0;
      PH_STOP_A: begin
        result.clk_line = 1'b0;
        result.dio_line = 1'b0;
      end
      PH_STOP_B:   result.dio_line = 1'b0;
      PH_STOP_C:   result.frame_done = (fs_inc >= FRAME_COUNT);
      default:     result.busy_res = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

/* test/tb_led_driver_two_wire_frame_sender.sv */
// tb_led_driver_two_wire_frame_sender: self-checking bench for the two-wire led frame sender
// a tick-level line predictor runs alongside the block; random idling on both channels
// depends on ldtw_pkg and led_driver_two_wire_frame_sender
`timescale 1ns / 1ps

module tb_led_driver_two_wire_frame_sender;
  import ldtw_pkg::*;

  // action 3 is unused by the block and behaves as a plain tick
  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam int DIGIT_COUNT = DIGITS_DEFAULT;
  // random traffic tops the run up to about this many items in total
  localparam int ITEM_TARGET = 850;
  localparam int PRINT_CAP = 40;

  // clock and synchronous reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // block inputs, all known from time zero
  logic        item_valid   = 1'b0;
  item_t       item_word    = '0;
  logic        result_stall = 1'b0;
  logic        cfg_we       = 1'b0;
  logic        cfg_index    = 1'b0;
  logic [7:0]  cfg_data     = 8'h00;

  logic        item_stall;
  logic        result_valid;
  result_t     result_word;

  led_driver_two_wire_frame_sender u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result_word),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // line predictor: its own copy of the sequencer state and both registers
  // ---------------------------------------------------------------------------
  phase_t      seq_phase   = PH_IDLE;
  logic [3:0]  bits_sent   = 4'd0;
  logic [7:0]  shift_reg   = 8'h00;
  logic [2:0]  frame_idx   = FRAME_CMD;
  logic [2:0]  byte_no     = 3'd0;
  logic        solo        = 1'b0;
  logic [1:0]  pos_held    = 2'd0;
  logic [7:0]  digit_store [DIGIT_COUNT];
  logic        ack_sticky  = 1'b0;
  logic [2:0]  bright_cfg  = BRIGHTNESS_RESET;
  logic [7:0]  addr_cfg    = START_ADDRESS_RESET;

  // line levels still owed by the block, oldest first
  result_t     expected_lines [$];

  int          mismatches  = 0;
  int          lines_seen  = 0;
  int          items_sent  = 0;

  // idling controls shared by the sender task and the receiver process
  bit          no_gaps      = 1'b0;
  bit          no_stalls    = 1'b0;
  int          hold_pending = 0;
  int          hold_left    = 0;
  int          stall_left   = 0;

  string       field_name [7] = '{"clk_line", "dio_line", "dio_drive", "busy_res",
                                  "refused", "ack_missing", "frame_done"};

  // bytes in the current frame: one for command and control, address plus digits otherwise
  function automatic int frame_bytes();
    if (frame_idx == FRAME_DATA) begin
      return solo ? 2 : DIGIT_COUNT + 1;
    end
    return 1;
  endfunction

  function automatic void load_next_byte();
    int k;
    if (frame_idx == FRAME_CMD) begin
      shift_reg = solo ? CMD_DATA_FIXED : CMD_DATA_AUTO;
    end else if (frame_idx == FRAME_DATA) begin
      if (byte_no == 3'd0) begin
        // address out of range goes out as written
        shift_reg = solo ? (CMD_ADDR_BASE | {6'd0, pos_held}) : addr_cfg;
      end else begin
        k = solo ? 0 : int'(byte_no) - 1;
        shift_reg = (k < DIGIT_COUNT) ? digit_store[k] : 8'h00;
      end
    end else begin
      shift_reg = CMD_DISPLAY_ON + {5'd0, bright_cfg};
    end
    bits_sent = 4'd0;
  endfunction

  // one half-bit tick: advance the predicted sequencer, return the expected line levels
  function automatic result_t predict_tick(input item_t it);
    result_t r;
    logic    req;
    req = (it.action == ACT_UPDATE) || (it.action == ACT_SINGLE);
    r.clk_line   = 1'b1;
    r.dio_line   = 1'b1;
    r.dio_drive  = 1'b1;
    r.busy_res   = 1'b1;
    r.refused    = 1'b0;
    r.frame_done = 1'b0;

    // the tick that takes a request already carries the first start level
    if (seq_phase == PH_IDLE) begin
      if (req) begin
        solo     = (it.action == ACT_SINGLE);
        pos_held = it.position;
        digit_store[0] = it.seg_a;
        digit_store[1] = it.seg_b;
        digit_store[2] = it.seg_c;
        digit_store[3] = it.seg_d;
        frame_idx = FRAME_CMD;
        byte_no   = 3'd0;
        load_next_byte();
        seq_phase = PH_START_A;
      end
    end else if (req) begin
      r.refused = 1'b1;
    end

    case (seq_phase)
      PH_START_A: begin
        r.dio_line = 1'b0;
        seq_phase  = PH_START_B;
      end
      PH_START_B: begin
        r.clk_line = 1'b0;
        r.dio_line = 1'b0;
        seq_phase  = PH_BIT_LOW;
      end
      PH_BIT_LOW: begin
        r.clk_line = 1'b0;
        r.dio_line = shift_reg[0];
        seq_phase  = PH_BIT_HIGH;
      end
      PH_BIT_HIGH: begin
        r.dio_line = shift_reg[0];
        shift_reg  = shift_reg >> 1;
        bits_sent  = bits_sent + 4'd1;
        seq_phase  = (bits_sent >= 4'd8) ? PH_ACK_LOW : PH_BIT_LOW;
      end
      PH_ACK_LOW: begin
        r.clk_line  = 1'b0;
        r.dio_drive = 1'b0;
        seq_phase   = PH_ACK_HIGH;
      end
      PH_ACK_HIGH: begin
        // data line sampled here: high means the driver did not acknowledge
        r.dio_drive = 1'b0;
        if (it.dio_in) begin
          ack_sticky = 1'b1;
        end
        byte_no = byte_no + 3'd1;
        if (int'(byte_no) < frame_bytes()) begin
          load_next_byte();
          seq_phase = PH_BIT_LOW;
        end else begin
          seq_phase = PH_STOP_A;
        end
      end
      PH_STOP_A: begin
        r.clk_line = 1'b0;
        r.dio_line = 1'b0;
        seq_phase  = PH_STOP_B;
      end
      PH_STOP_B: begin
        r.dio_line = 1'b0;
        seq_phase  = PH_STOP_C;
      end
      PH_STOP_C: begin
        frame_idx = frame_idx + 3'd1;
        if (frame_idx < FRAME_COUNT) begin
          byte_no = 3'd0;
          load_next_byte();
          seq_phase = PH_START_A;
        end else begin
          frame_idx    = FRAME_CMD;
          byte_no      = 3'd0;
          seq_phase    = PH_IDLE;
          r.frame_done = 1'b1;
        end
      end
      default: begin
        seq_phase  = PH_IDLE;
        r.busy_res = 1'b0;
      end
    endcase
    r.ack_missing = ack_sticky;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) begin
      $display("mismatch: %s", msg);
    end
    mismatches++;
  endtask

  task automatic check_line(input result_t got);
    result_t    want;
    logic [6:0] g;
    logic [6:0] w;
    if (expected_lines.size() == 0) begin
      report_mismatch($sformatf("result %b with nothing expected", got));
      return;
    end
    want = expected_lines.pop_front();
    g = got;
    w = want;
    for (int i = 0; i < 7; i++) begin
      if (g[6-i] !== w[6-i]) begin
        report_mismatch($sformatf("tick %0d %s: got %b expected %b",
                                  lines_seen, field_name[i], g[6-i], w[6-i]));
      end
    end
    lines_seen++;
  endtask

  // result transfers are taken on the edge that sees valid high and stall low
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      check_line(result_word);
    end
  end

  // ---------------------------------------------------------------------------
  // idling
  // ---------------------------------------------------------------------------
  // mostly no gap, often a short one, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 40);
  endfunction

  // receiver: random stall runs, a counted long hold on request, none in quiet stretches
  always @(posedge clk) begin
    if (hold_pending != 0) begin
      hold_left    = hold_pending;
      hold_pending = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else if (no_stalls) begin
      stall_left = 0;
      result_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else begin
      stall_left = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      result_stall <= (stall_left != 0);
      if (stall_left != 0) begin
        stall_left--;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------
  // offer one tick, hold it until the transfer happens, then record what it should yield
  task automatic send_item(input item_t it);
    int gap;
    gap = no_gaps ? 0 : gap_len();
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item_word  <= it;
    @(posedge clk);
    while (item_stall !== 1'b0) @(posedge clk);
    expected_lines.push_back(predict_tick(it));
    items_sent++;
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    while (expected_lines.size() != 0) @(posedge clk);
  endtask

  function automatic item_t request_item(input logic [1:0] act, input logic [1:0] pos,
                                         input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c, input logic [7:0] d);
    item_t it;
    it.action   = act;
    it.position = pos;
    it.seg_a    = a;
    it.seg_b    = b;
    it.seg_c    = c;
    it.seg_d    = d;
    it.dio_in   = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // tick with random content; req_pct of them carry a request, miss_pct of ack samples are high
  function automatic item_t busy_tick(input int req_pct, input int miss_pct);
    item_t it;
    int    r;
    it = request_item(ACT_TICK, 2'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom), 8'($urandom));
    r = $urandom_range(0, 99);
    if (r < req_pct) begin
      it.action = $urandom_range(0, 1) ? ACT_UPDATE : ACT_SINGLE;
    end else if (r < req_pct + 10) begin
      it.action = ACT_SPARE;
    end
    if (seq_phase == PH_ACK_HIGH) begin
      it.dio_in = ($urandom_range(0, 99) < miss_pct);
    end
    return it;
  endfunction

  function automatic item_t random_request();
    return request_item($urandom_range(0, 1) ? ACT_UPDATE : ACT_SINGLE, 2'($urandom),
                        8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  task automatic run_to_idle(input int req_pct, input int miss_pct);
    while (seq_phase != PH_IDLE) send_item(busy_tick(req_pct, miss_pct));
  endtask

  // registers change only with the sequencer idle and nothing in flight
  task automatic set_reg(input logic idx, input logic [7:0] value);
    run_to_idle(5, 0);
    wait_drained();
    repeat (3) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_BRIGHTNESS) begin
      bright_cfg = value[2:0];
    end else begin
      addr_cfg = value;
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // idle ticks, including the unused action, with field extremes
  task automatic test_idle_ticks();
    item_t it;
    it = request_item(ACT_TICK, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00);
    it.dio_in = 1'b0;
    send_item(it);
    it = request_item(ACT_SPARE, 2'd3, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    it.dio_in = 1'b1;
    send_item(it);
    send_item(request_item(ACT_TICK, 2'd2, 8'hA5, 8'h5A, 8'h0F, 8'hF0));
  endtask

  // four-digit update under reset settings; a request on the closing tick is refused
  task automatic test_update_sequence();
    send_item(request_item(ACT_UPDATE, 2'd1, 8'h00, 8'hFF, 8'hA5, 8'h5A));
    while (!(seq_phase == PH_STOP_C && frame_idx == FRAME_CTRL)) begin
      send_item(busy_tick(0, 0));
    end
    send_item(request_item(ACT_SINGLE, 2'd2, 8'h3C, 8'hC3, 8'h00, 8'hFF));
    send_item(busy_tick(0, 0));
  endtask

  // one-digit write at the last position, brightness zero, requests thrown in while busy
  task automatic test_single_with_refusals();
    set_reg(REG_BRIGHTNESS, 8'hF8);
    set_reg(REG_START_ADDRESS, 8'hC3);
    send_item(request_item(ACT_SINGLE, 2'd3, 8'h81, 8'h7E, 8'h18, 8'hE7));
    run_to_idle(20, 0);
    send_item(busy_tick(0, 0));
  endtask

  // out-of-range start address, then one unacknowledged byte sets the sticky flag
  task automatic test_missing_ack();
    set_reg(REG_START_ADDRESS, 8'h00);
    set_reg(REG_BRIGHTNESS, 8'h07);
    send_item(request_item(ACT_UPDATE, 2'd0, 8'h12, 8'h34, 8'h56, 8'h78));
    while (!(frame_idx == FRAME_DATA && seq_phase == PH_ACK_HIGH)) begin
      send_item(busy_tick(0, 0));
    end
    send_item(busy_tick(0, 100));
    run_to_idle(0, 0);
  endtask

  // long receiver hold so the block fills and stalls its input, then a full drain,
  // then a stretch at full rate with no idling on either side
  task automatic test_back_pressure();
    run_to_idle(0, 0);
    no_gaps = 1'b1;
    hold_pending = 80;
    send_item(random_request());
    for (int i = 0; i < 40; i++) begin
      send_item(busy_tick(5, 0));
    end
    no_gaps = 1'b0;
    wait_drained();
    no_gaps   = 1'b1;
    no_stalls = 1'b1;
    for (int i = 0; i < 150; i++) begin
      if (seq_phase == PH_IDLE) begin
        send_item(random_request());
      end else begin
        send_item(busy_tick(5, 2));
      end
    end
    no_gaps   = 1'b0;
    no_stalls = 1'b0;
  endtask

  // random traffic: phases of mostly well-formed sequences, settings changed between phases
  task automatic test_random_traffic();
    int step_no;
    logic [2:0] b;
    logic [7:0] a;
    for (int phase_no = 0; items_sent < ITEM_TARGET; phase_no++) begin
      case (phase_no % 4)
        0: begin
          b = 3'd0;
          a = START_ADDRESS_RESET;
        end
        1: begin
          b = 3'd7;
          a = CMD_ADDR_BASE | 8'h03;
        end
        2: begin
          b = 3'($urandom);
          a = CMD_ADDR_BASE | 8'($urandom_range(0, 3));
        end
        default: begin
          b = 3'($urandom);
          a = 8'($urandom);
        end
      endcase
      set_reg(REG_BRIGHTNESS, {5'($urandom), b});
      set_reg(REG_START_ADDRESS, a);
      step_no = 0;
      while (step_no < 50 && items_sent < ITEM_TARGET) begin
        if (seq_phase == PH_IDLE && $urandom_range(0, 99) < 85) begin
          send_item(random_request());
        end else begin
          send_item(busy_tick(6, 3));
        end
        step_no++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      digit_store[i] = 8'h00;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_ticks();
    test_update_sequence();
    test_single_with_refusals();
    test_missing_ack();
    test_back_pressure();
    test_random_traffic();

    // let the last transfers come back, then allow for the block's latency
    wait_drained();
    repeat (10) @(posedge clk);
    if (expected_lines.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_lines.size()));
    end
    if (mismatches == 0) begin
      $display("[led_driver_two_wire_frame_sender] OK");
    end else begin
      $display("[led_driver_two_wire_frame_sender] ERROR");
    end
    $finish;
  end

  // watchdog well beyond the slowest legal run
  initial begin
    #5000000;
    $display("timeout: %0d results still expected", expected_lines.size());
    $display("[led_driver_two_wire_frame_sender] ERROR");
    $finish;
  end

endmodule
